@@ src/rfd_pkg.sv @@
// Shared types and constants for the range finder reply deframer.
package rfd_pkg;

    // Payload lengths of the two known reply kinds, in bytes.
    localparam int STATUS_PAYLOAD_BYTES = 4;
    localparam int RANGE_PAYLOAD_BYTES  = 20;

    // Payload byte counter width; it covers the longest payload.
    localparam int CNT_W = 5;

    // Reset value of the sync byte register.
    localparam logic [7:0] SYNC_RESET = 8'h59;

    // Configuration register indexes.
    localparam logic [1:0] CFG_IDX_SYNC   = 2'd0;
    localparam logic [1:0] CFG_IDX_STATUS = 2'd1;
    localparam logic [1:0] CFG_IDX_RANGE  = 2'd2;

    // Status payload byte that carries the flags, and the lowest flag bit.
    localparam logic [CNT_W-1:0] STATUS_FLAG_BYTE = CNT_W'(2);
    localparam int               FLAG_LSB         = 1;
    localparam int               NUM_FLAGS        = 5;

    // Payload offsets of the three little-endian range words.
    localparam int NUM_RANGES = 3;
    localparam logic [CNT_W-1:0] RANGE_WORD_OFS [NUM_RANGES] = '{
        CNT_W'(0), CNT_W'(6), CNT_W'(12)
    };

    // Kind of a finished frame.
    typedef enum logic [1:0] {
        KIND_STATUS = 2'd0,
        KIND_RANGE  = 2'd1,
        KIND_DROP   = 2'd2
    } t_kind;

    // Programmable decode values.
    typedef struct packed {
        logic [7:0] sync_value;
        logic [7:0] status_opcode;
        logic [7:0] range_opcode;
    } t_cfg;

    // One result beat.
    typedef struct packed {
        t_kind                frame_kind;
        logic [7:0]           command_byte;
        logic [NUM_FLAGS-1:0] flags;
        logic [31:0]          range_first;
        logic [31:0]          range_second;
        logic [31:0]          range_third;
    } t_result;

endpackage

@@ src/rfd_parser.sv @@
// Frame parser: sync hunt, command decode and payload capture for one byte a cycle while i_fire is high.
module rfd_parser
    import rfd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_fire,
    input  logic [7:0] i_byte,
    input  t_cfg       i_cfg,
    output logic       o_res_valid,
    output t_result    o_res
);

    typedef enum logic [2:0] {
        PH_HUNT    = 3'b001,
        PH_CMD     = 3'b010,
        PH_PAYLOAD = 3'b100
    } t_phase;

    localparam logic [CNT_W:0] STATUS_LEN = (CNT_W+1)'(STATUS_PAYLOAD_BYTES);
    localparam logic [CNT_W:0] RANGE_LEN  = (CNT_W+1)'(RANGE_PAYLOAD_BYTES);

    t_phase           r_phase,   n_phase;
    logic             r_is_range, n_is_range;
    logic [CNT_W-1:0] r_count,   n_count;
    logic [7:0]       r_command, n_command;
    logic [7:0]       r_status,  n_status;
    logic [31:0]      r_ranges [NUM_RANGES];
    logic [31:0]      n_ranges [NUM_RANGES];

    logic [CNT_W-1:0] rel;
    logic [CNT_W:0]   frame_len;
    logic             last_byte;

    // The frame ends on the byte whose position reaches the payload length.
    assign frame_len = r_is_range ? RANGE_LEN : STATUS_LEN;
    assign last_byte = (({1'b0, r_count} + (CNT_W+1)'(1)) >= frame_len);

    // Next state and the result caused by the current byte.
    always_comb begin
        n_phase     = r_phase;
        n_is_range  = r_is_range;
        n_count     = r_count;
        n_command   = r_command;
        n_status    = r_status;
        n_ranges    = r_ranges;
        rel         = '0;
        o_res_valid = 1'b0;
        o_res       = '0;
        if (i_fire) begin
            case (r_phase)
                PH_CMD: begin
                    n_command = i_byte;
                    n_count   = '0;
                    if (i_byte == i_cfg.status_opcode) begin
                        n_is_range = 1'b0;
                        n_phase    = PH_PAYLOAD;
                    end else if (i_byte == i_cfg.range_opcode) begin
                        n_is_range = 1'b1;
                        n_phase    = PH_PAYLOAD;
                    end else begin
                        // Unknown command: report it and go back to hunting.
                        n_phase            = PH_HUNT;
                        o_res_valid        = 1'b1;
                        o_res.frame_kind   = KIND_DROP;
                        o_res.command_byte = i_byte;
                    end
                end
                PH_PAYLOAD: begin
                    // Capture payload bytes that fall inside a range word, or the status flag byte.
                    if (r_is_range) begin
                        for (int w = 0; w < NUM_RANGES; w++) begin
                            rel = r_count - RANGE_WORD_OFS[w];
                            if (r_count >= RANGE_WORD_OFS[w] && rel < CNT_W'(4)) begin
                                n_ranges[w][{rel[1:0], 3'b000} +: 8] = i_byte;
                            end
                        end
                    end else if (r_count == STATUS_FLAG_BYTE) begin
                        n_status = i_byte;
                    end
                    if (last_byte) begin
                        n_phase            = PH_HUNT;
                        n_count            = '0;
                        o_res_valid        = 1'b1;
                        o_res.command_byte = r_command;
                        if (r_is_range) begin
                            o_res.frame_kind   = KIND_RANGE;
                            o_res.range_first  = n_ranges[0];
                            o_res.range_second = n_ranges[1];
                            o_res.range_third  = n_ranges[2];
                        end else begin
                            o_res.frame_kind = KIND_STATUS;
                            o_res.flags      = n_status[FLAG_LSB +: NUM_FLAGS];
                        end
                    end else begin
                        n_count = r_count + CNT_W'(1);
                    end
                end
                default: begin
                    // Hunting: wait for the sync byte.
                    n_phase = (i_byte == i_cfg.sync_value) ? PH_CMD : PH_HUNT;
                end
            endcase
        end
    end

    // Parser state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_HUNT;
            r_is_range <= 1'b0;
            r_count    <= '0;
            r_command  <= '0;
            r_status   <= '0;
            for (int w = 0; w < NUM_RANGES; w++) begin
                r_ranges[w] <= '0;
            end
        end else begin
            r_phase    <= n_phase;
            r_is_range <= n_is_range;
            r_count    <= n_count;
            r_command  <= n_command;
            r_status   <= n_status;
            r_ranges   <= n_ranges;
        end
    end

    // The payload counter stays inside the open frame.
    a_count_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_PAYLOAD) |-> ({1'b0, r_count} < frame_len))
        else $error("payload counter beyond frame length");

    // Outside a payload the counter is parked at zero.
    a_count_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase != PH_PAYLOAD) |-> (r_count == '0))
        else $error("payload counter not cleared outside a payload");

    // The phase register always holds exactly one state.
    a_phase_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_phase))
        else $error("parse phase not one-hot");

endmodule

@@ src/rangefinder_reply_deframer.sv @@
// Top level of the range finder reply deframer: config registers, input skid and result register.
//
// Usage:
//   Received bytes enter on the rx channel (i_rx_valid, o_rx_stall, i_rx_byte).
//   Each completed frame, and each unknown command byte, produces one result
//   beat on the result channel (o_res_valid, i_res_stall and the o_ fields).
//   Fields without meaning for the frame kind read as zero.
//   The configuration channel (i_cfg_valid, o_cfg_ready, i_cfg_index,
//   i_cfg_data) writes sync_value, status_opcode and range_opcode; it is always
//   ready and an index beyond the last register is ignored.
//   Throughput is one byte per cycle while a waiting result is not stalled; the
//   parser updates its state once per byte. The result is registered and appears
//   in the cycle after the parser takes the byte that ends the frame.
//   When the receiver stalls, the waiting result holds and one more byte is
//   taken into a skid register; o_rx_stall then rises until the result moves.
//   Reset (synchronous, active low) returns the parser to sync hunt, empties
//   the result and skid registers and restores sync_value to 0x59 with both
//   opcodes at zero.
module rangefinder_reply_deframer
    import rfd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_rx_valid,
    output logic        o_rx_stall,
    input  logic [7:0]  i_rx_byte,
    output logic        o_res_valid,
    input  logic        i_res_stall,
    output logic [1:0]  o_frame_kind,
    output logic [7:0]  o_command_byte,
    output logic        o_flag_mt,
    output logic        o_flag_nt,
    output logic        o_flag_err,
    output logic        o_flag_nr,
    output logic        o_flag_tte,
    output logic [31:0] o_range_first,
    output logic [31:0] o_range_second,
    output logic [31:0] o_range_third,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data
);

    t_cfg       r_cfg;
    logic       r_skid_valid;
    logic [7:0] r_skid_byte;
    logic       r_out_valid;
    t_result    r_out;

    logic       out_free;
    logic       src_valid;
    logic [7:0] src_byte;
    logic       fire;
    logic       rx_accept;
    logic       par_valid;
    t_result    par_res;

    // Configuration registers.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sync_value    <= SYNC_RESET;
            r_cfg.status_opcode <= '0;
            r_cfg.range_opcode  <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_IDX_SYNC:   r_cfg.sync_value    <= i_cfg_data;
                CFG_IDX_STATUS: r_cfg.status_opcode <= i_cfg_data;
                CFG_IDX_RANGE:  r_cfg.range_opcode  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Byte source: the skid register has priority over the port.
    assign out_free   = !r_out_valid || !i_res_stall;
    assign src_valid  = r_skid_valid || i_rx_valid;
    assign src_byte   = r_skid_valid ? r_skid_byte : i_rx_byte;
    assign fire       = src_valid && out_free;
    assign rx_accept  = i_rx_valid && !r_skid_valid;
    assign o_rx_stall = r_skid_valid;

    // Skid register catches one byte while the result register is blocked.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            r_skid_valid <= !out_free;
        end else begin
            r_skid_valid <= rx_accept && !out_free;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rx_accept && !out_free) begin
            r_skid_byte <= i_rx_byte;
        end
    end

    rfd_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (fire),
        .i_byte      (src_byte),
        .i_cfg       (r_cfg),
        .o_res_valid (par_valid),
        .o_res       (par_res)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= par_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && par_valid) begin
            r_out <= par_res;
        end
    end

    assign o_res_valid    = r_out_valid;
    assign o_frame_kind   = r_out.frame_kind;
    assign o_command_byte = r_out.command_byte;
    assign o_flag_mt      = r_out.flags[0];
    assign o_flag_nt      = r_out.flags[1];
    assign o_flag_err     = r_out.flags[2];
    assign o_flag_nr      = r_out.flags[3];
    assign o_flag_tte     = r_out.flags[4];
    assign o_range_first  = r_out.range_first;
    assign o_range_second = r_out.range_second;
    assign o_range_third  = r_out.range_third;

    // A byte is only parked in the skid register behind a waiting result.
    a_skid_behind_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid byte held without a waiting result");

    // A result that is stalled is never lost.
    a_result_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_res_stall) |=> (r_out_valid && $stable(r_out)))
        else $error("stalled result dropped or changed");

    // A parked byte leaves the skid register as soon as the result moves.
    a_skid_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && !i_res_stall) |=> !r_skid_valid)
        else $error("skid byte not drained");

endmodule
